### design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, disabled while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

### design/arpi_pkg.sv
// Types, constants and checksum helper for the ARP / ICMP receive responder.
`default_nettype none

package arpi_pkg;

    localparam int FRAME_WORDS = 21;
    localparam int IDX_W       = $clog2(FRAME_WORDS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_STN_MAC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STN_IP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BCAST_IP  = 2'd2;

    localparam logic [2:0] ACT_DROP      = 3'd0;
    localparam logic [2:0] ACT_ARP_REPLY = 3'd1;
    localparam logic [2:0] ACT_ECHO      = 3'd2;
    localparam logic [2:0] ACT_ARP_LEARN = 3'd3;
    localparam logic [2:0] ACT_UDP       = 3'd4;

    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [15:0] ETH_ARP       = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  ICMP_ECHO_REQ = 8'd8;
    localparam logic [15:0] ARP_OP_REQ    = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY  = 16'd2;

    localparam logic [15:0] IP_VER_IHL  = 16'h4500;
    localparam logic [15:0] IP_LEN      = 16'd28;
    localparam logic [15:0] IP_TTL_PROT = 16'h4001;
    localparam logic [15:0] IP_FIX_SUM  = 16'h851D;
    localparam logic [15:0] ARP_HTYPE   = 16'h0001;
    localparam logic [15:0] ARP_LENS    = 16'h0604;

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] eth_type;
        logic [31:0] l3_source_addr;
        logic [31:0] l3_dest_addr;
        logic [7:0]  ip_protocol;
        logic [7:0]  icmp_msg_type;
        logic [15:0] icmp_echo_id;
        logic [15:0] icmp_sequence;
        logic [15:0] arp_oper;
        logic [47:0] arp_sender_mac;
    } t_req;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] frame_word;
        logic        word_last;
        logic [31:0] learn_ip;
        logic [47:0] learn_mac;
    } t_rsp;

    typedef struct packed {
        logic [47:0] stn_mac;
        logic [31:0] stn_ip;
        logic [31:0] bcast_ip;
    } t_cfg;

    typedef logic [FRAME_WORDS-1:0][15:0] t_words;

    typedef struct packed {
        logic [2:0]  action;
        logic        sole;
        logic [31:0] learn_ip;
        logic [47:0] learn_mac;
        t_words      words;
    } t_frame;

    function automatic logic [15:0] ones_csum(input logic [18:0] sum);
        logic [16:0] fold1;
        logic [16:0] fold2;
        fold1 = {1'b0, sum[15:0]} + {14'b0, sum[18:16]};
        fold2 = {1'b0, fold1[15:0]} + {16'b0, fold1[16]};
        return ~fold2[15:0];
    endfunction

endpackage

`default_nettype wire

### design/arpi_decode.sv
// Frame classification and reply header build for one received request.
`default_nettype none

module arpi_decode (
    input  arpi_pkg::t_req   i_req,
    input  arpi_pkg::t_cfg   i_cfg,
    output arpi_pkg::t_frame o_frame
);
    import arpi_pkg::*;

    logic        mac_ok;
    logic        ip_ok;
    logic        arp_ok;
    logic [18:0] ip_sum;
    logic [18:0] icmp_sum;
    logic [15:0] ip_ck;
    logic [15:0] icmp_ck;
    t_words      echo_w;
    t_words      arp_w;

    assign mac_ok = (i_req.dest_mac == MAC_BCAST) || (i_req.dest_mac == i_cfg.stn_mac);
    assign ip_ok  = (i_req.l3_dest_addr == i_cfg.bcast_ip)
                 || (i_req.l3_dest_addr == i_cfg.stn_ip);
    assign arp_ok = (i_req.l3_dest_addr == i_cfg.stn_ip);

    assign ip_sum = {3'b0, IP_FIX_SUM}
                  + {3'b0, i_req.l3_dest_addr[31:16]} + {3'b0, i_req.l3_dest_addr[15:0]}
                  + {3'b0, i_req.l3_source_addr[31:16]} + {3'b0, i_req.l3_source_addr[15:0]};
    assign icmp_sum = {3'b0, i_req.icmp_echo_id} + {3'b0, i_req.icmp_sequence};
    assign ip_ck    = ones_csum(ip_sum);
    assign icmp_ck  = ones_csum(icmp_sum);

    always_comb begin
        echo_w[0]  = i_req.source_mac[47:32];
        echo_w[1]  = i_req.source_mac[31:16];
        echo_w[2]  = i_req.source_mac[15:0];
        echo_w[3]  = i_cfg.stn_mac[47:32];
        echo_w[4]  = i_cfg.stn_mac[31:16];
        echo_w[5]  = i_cfg.stn_mac[15:0];
        echo_w[6]  = ETH_IPV4;
        echo_w[7]  = IP_VER_IHL;
        echo_w[8]  = IP_LEN;
        echo_w[9]  = 16'h0000;
        echo_w[10] = 16'h0000;
        echo_w[11] = IP_TTL_PROT;
        echo_w[12] = ip_ck;
        echo_w[13] = i_req.l3_dest_addr[31:16];
        echo_w[14] = i_req.l3_dest_addr[15:0];
        echo_w[15] = i_req.l3_source_addr[31:16];
        echo_w[16] = i_req.l3_source_addr[15:0];
        echo_w[17] = 16'h0000;
        echo_w[18] = icmp_ck;
        echo_w[19] = i_req.icmp_echo_id;
        echo_w[20] = i_req.icmp_sequence;

        arp_w[0]  = i_req.arp_sender_mac[47:32];
        arp_w[1]  = i_req.arp_sender_mac[31:16];
        arp_w[2]  = i_req.arp_sender_mac[15:0];
        arp_w[3]  = i_cfg.stn_mac[47:32];
        arp_w[4]  = i_cfg.stn_mac[31:16];
        arp_w[5]  = i_cfg.stn_mac[15:0];
        arp_w[6]  = ETH_ARP;
        arp_w[7]  = ARP_HTYPE;
        arp_w[8]  = ETH_IPV4;
        arp_w[9]  = ARP_LENS;
        arp_w[10] = ARP_OP_REPLY;
        arp_w[11] = i_cfg.stn_mac[47:32];
        arp_w[12] = i_cfg.stn_mac[31:16];
        arp_w[13] = i_cfg.stn_mac[15:0];
        arp_w[14] = i_cfg.stn_ip[31:16];
        arp_w[15] = i_cfg.stn_ip[15:0];
        arp_w[16] = i_req.arp_sender_mac[47:32];
        arp_w[17] = i_req.arp_sender_mac[31:16];
        arp_w[18] = i_req.arp_sender_mac[15:0];
        arp_w[19] = i_req.l3_source_addr[31:16];
        arp_w[20] = i_req.l3_source_addr[15:0];
    end

    always_comb begin
        o_frame.action    = ACT_DROP;
        o_frame.learn_ip  = '0;
        o_frame.learn_mac = '0;
        if (mac_ok) begin
            if (i_req.eth_type == ETH_IPV4) begin
                if (ip_ok) begin
                    if (i_req.ip_protocol == PROTO_UDP) begin
                        o_frame.action = ACT_UDP;
                    end else if (i_req.ip_protocol == PROTO_ICMP
                                 && i_req.icmp_msg_type == ICMP_ECHO_REQ) begin
                        o_frame.action = ACT_ECHO;
                    end
                end
            end else if (i_req.eth_type == ETH_ARP) begin
                if (arp_ok) begin
                    if (i_req.arp_oper == ARP_OP_REPLY) begin
                        o_frame.action    = ACT_ARP_LEARN;
                        o_frame.learn_ip  = i_req.l3_source_addr;
                        o_frame.learn_mac = i_req.arp_sender_mac;
                    end else if (i_req.arp_oper == ARP_OP_REQ) begin
                        o_frame.action = ACT_ARP_REPLY;
                    end
                end
            end
        end
        o_frame.sole  = (o_frame.action != ACT_ECHO) && (o_frame.action != ACT_ARP_REPLY);
        o_frame.words = (o_frame.action == ACT_ECHO) ? echo_w : arp_w;
    end

endmodule

`default_nettype wire

### design/arpi_tx.sv
// Result register and halfword serializer for decoded frames.
`default_nettype none

module arpi_tx (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_load,
    input  arpi_pkg::t_frame i_frame,
    input  wire              i_stall,
    output logic             o_valid,
    output arpi_pkg::t_rsp   o_rsp,
    output logic             o_free
);
    import arpi_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_WORDS - 1);

    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    t_frame           r_frm;
    logic             fire;
    logic             last;

    assign fire   = r_valid && !i_stall;
    assign last   = r_frm.sole || (r_idx == LAST_IDX);
    assign o_free = !r_valid || (fire && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (fire && last) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frm <= i_frame;
        end
    end

    assign o_valid          = r_valid;
    assign o_rsp.action     = r_frm.action;
    assign o_rsp.frame_word = r_frm.sole ? 16'h0000 : r_frm.words[r_idx];
    assign o_rsp.word_last  = last;
    assign o_rsp.learn_ip   = r_frm.learn_ip;
    assign o_rsp.learn_mac  = r_frm.learn_mac;

endmodule

`default_nettype wire

### design/arp_icmp_rx_responder.sv
// ARP / ICMP echo receive responder: top level with request and config registers.
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in) carries the parsed headers
//   of one received Ethernet frame. Response channel (o_out_valid / i_out_stall /
//   o_out) returns either one sole result (drop, UDP deliver, ARP learn) or a
//   21-halfword reply frame (ARP reply, ICMP echo reply), word_last on the end.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data) sets local MAC, local IP
//   and broadcast IP; write it only while no request is in flight.
// Path: a request passes from the request register into the serializer's result
//   register; it waits in the request register while the serializer is busy.
// Throughput: the serializer emits one halfword per cycle while the response is
//   not stalled. The request register takes the next request while the serializer
//   drains, and hands it over on the cycle the last word is taken.
// Reset: clears both valid flags; local MAC and IP to zero, broadcast IP to
//   all ones.
// Stall: a stalled response holds its word; the request register fills and
//   then o_in_stall rises until the serializer frees.
`default_nettype none

module arp_icmp_rx_responder (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  arpi_pkg::t_req                       i_in,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output arpi_pkg::t_rsp                       o_out,
    input  wire                                  i_cfg_we,
    input  wire [arpi_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [arpi_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import arpi_pkg::*;

    t_cfg   r_cfg;
    logic   r_in_valid;
    t_req   r_in;
    t_frame dec_frame;
    logic   tx_free;
    logic   in_fire;
    logic   load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stn_mac  <= '0;
            r_cfg.stn_ip   <= '0;
            r_cfg.bcast_ip <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STN_MAC:  r_cfg.stn_mac  <= i_cfg_data;
                CFG_STN_IP:   r_cfg.stn_ip   <= i_cfg_data[31:0];
                CFG_BCAST_IP: r_cfg.bcast_ip <= i_cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    assign load       = r_in_valid && tx_free;
    assign o_in_stall = r_in_valid && !tx_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in;
        end
    end

    arpi_decode u_decode (
        .i_req   (r_in),
        .i_cfg   (r_cfg),
        .o_frame (dec_frame)
    );

    arpi_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_frame (dec_frame),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_rsp   (o_out),
        .o_free  (tx_free)
    );

endmodule

`default_nettype wire

### design/arpi_checker.sv
// Port-level checker for the ARP / ICMP receive responder, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module arpi_checker (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             o_in_stall,
    input wire             o_out_valid,
    input wire             i_out_stall,
    input arpi_pkg::t_rsp  o_out
);
    import arpi_pkg::*;

    logic out_hold;
    logic out_mid;
    logic run_act;
    logic sole_act;
    logic sole_clear;

    assign out_hold   = o_out_valid && i_out_stall;
    assign out_mid    = o_out_valid && !i_out_stall && !o_out.word_last;
    assign run_act    = (o_out.action == ACT_ECHO) || (o_out.action == ACT_ARP_REPLY);
    assign sole_act   = o_out_valid && (o_out.action == ACT_DROP || o_out.action == ACT_UDP);
    assign sole_clear = (o_out.frame_word == 16'h0000) && (o_out.learn_ip == 32'h0)
                     && (o_out.learn_mac == 48'h0) && o_out.word_last;

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_hold |=> o_out_valid && $stable(o_out), "stalled response changed")
    `ASSERT_IMPL(a_run_action, i_clk, i_rst_n, o_out_valid && !o_out.word_last, run_act, "multi-word run")
    `ASSERT_IMPL(a_sole_zero, i_clk, i_rst_n, sole_act, sole_clear, "sole result fields not clear")
    `ASSERT_CLK(a_run_cont, i_clk, i_rst_n, out_mid |=> o_out_valid && run_act, "frame broken mid-run")
    `ASSERT_IMPL(a_in_busy, i_clk, i_rst_n, o_in_stall, o_out_valid, "request stalled while idle")

endmodule

bind arp_icmp_rx_responder arpi_checker u_arpi_checker (.*);

`default_nettype wire

### sim/arp_icmp_rx_responder_tb.sv
// Self-checking testbench for the ARP / ICMP echo receive responder.
module arp_icmp_rx_responder_tb;
    import arpi_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum {FR_ECHO, FR_UDP, FR_ARP_REQ, FR_ARP_REP, FR_NOISE} t_frame_kind;
    typedef enum {SNK_FREE, SNK_LIGHT, SNK_HEAVY} t_sink_mode;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_req                  in_req = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_rsp                  out_rsp;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // station settings as last written
    logic [47:0] st_mac = '0;
    logic [31:0] st_ip = '0;
    logic [31:0] st_bip = 32'hFFFF_FFFF;

    t_req frame_q[$];
    t_rsp reply_q[$];
    int   n_req_sent = 0;
    int   n_req_acc = 0;
    int   n_words = 0;
    int   errors = 0;
    int   cycles = 0;
    int   act_seen[8];

    logic       src_idle_on = 1'b0;
    t_sink_mode snk_mode = SNK_FREE;
    logic [3:0] snk_tick = '0;
    logic [15:0] snk_pat = '0;

    arp_icmp_rx_responder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    function automatic logic [15:0] ones_fold(input logic [31:0] s);
        while (s > 32'h0000_FFFF)
            s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        return ~s[15:0];
    endfunction

    // Expected responses for one accepted request.
    task automatic predict_reply(input t_req r);
        logic [15:0] fw [21];
        logic [31:0] s;
        logic [2:0]  act;
        logic [31:0] lip;
        logic [47:0] lmac;
        t_rsp        e;
        act = ACT_DROP;
        lip = '0;
        lmac = '0;
        for (int k = 0; k < 21; k++) fw[k] = '0;
        if (r.dest_mac == MAC_BCAST || r.dest_mac == st_mac) begin
            if (r.eth_type == ETH_IPV4) begin
                if (r.l3_dest_addr == st_bip || r.l3_dest_addr == st_ip) begin
                    if (r.ip_protocol == PROTO_UDP) begin
                        act = ACT_UDP;
                    end else if (r.ip_protocol == PROTO_ICMP
                                 && r.icmp_msg_type == ICMP_ECHO_REQ) begin
                        act = ACT_ECHO;
                        {fw[0], fw[1], fw[2]} = r.source_mac;
                        {fw[3], fw[4], fw[5]} = st_mac;
                        fw[6] = ETH_IPV4;
                        fw[7] = IP_VER_IHL;
                        fw[8] = IP_LEN;
                        fw[11] = IP_TTL_PROT;
                        {fw[13], fw[14]} = r.l3_dest_addr;
                        {fw[15], fw[16]} = r.l3_source_addr;
                        s = '0;
                        for (int k = 7; k < 17; k++) s += fw[k];
                        fw[12] = ones_fold(s);
                        fw[19] = r.icmp_echo_id;
                        fw[20] = r.icmp_sequence;
                        fw[18] = ones_fold({16'd0, fw[19]} + {16'd0, fw[20]});
                    end
                end
            end else if (r.eth_type == ETH_ARP && r.l3_dest_addr == st_ip) begin
                if (r.arp_oper == ARP_OP_REPLY) begin
                    act = ACT_ARP_LEARN;
                    lip = r.l3_source_addr;
                    lmac = r.arp_sender_mac;
                end else if (r.arp_oper == ARP_OP_REQ) begin
                    act = ACT_ARP_REPLY;
                    {fw[0], fw[1], fw[2]} = r.arp_sender_mac;
                    {fw[3], fw[4], fw[5]} = st_mac;
                    fw[6] = ETH_ARP;
                    fw[7] = ARP_HTYPE;
                    fw[8] = ETH_IPV4;
                    fw[9] = ARP_LENS;
                    fw[10] = ARP_OP_REPLY;
                    {fw[11], fw[12], fw[13]} = st_mac;
                    {fw[14], fw[15]} = st_ip;
                    {fw[16], fw[17], fw[18]} = r.arp_sender_mac;
                    {fw[19], fw[20]} = r.l3_source_addr;
                end
            end
        end
        act_seen[act]++;
        if (act == ACT_ECHO || act == ACT_ARP_REPLY) begin
            for (int k = 0; k < 21; k++) begin
                e.action = act;
                e.frame_word = fw[k];
                e.word_last = (k == 20);
                e.learn_ip = '0;
                e.learn_mac = '0;
                reply_q.push_back(e);
            end
        end else begin
            e.action = act;
            e.frame_word = '0;
            e.word_last = 1'b1;
            e.learn_ip = lip;
            e.learn_mac = lmac;
            reply_q.push_back(e);
        end
    endtask

    // Headers of the given kind with random content; FR_NOISE gives fully random headers.
    function automatic t_req make_frame(input t_frame_kind kind);
        t_req r;
        int   pick;
        r = {rand48(), rand48(), 16'($urandom), $urandom, $urandom, 8'($urandom),
             8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), rand48()};
        if (kind == FR_NOISE) return r;
        pick = $urandom_range(0, 9);
        r.dest_mac = (pick < 7) ? st_mac : (pick < 9) ? MAC_BCAST : rand48();
        r.l3_dest_addr = $urandom_range(0, 3) ? st_ip : st_bip;
        case (kind)
            FR_ECHO: begin
                r.eth_type = ETH_IPV4;
                r.ip_protocol = PROTO_ICMP;
                r.icmp_msg_type = ICMP_ECHO_REQ;
            end
            FR_UDP: begin
                r.eth_type = ETH_IPV4;
                r.ip_protocol = PROTO_UDP;
            end
            FR_ARP_REQ: begin
                r.eth_type = ETH_ARP;
                r.l3_dest_addr = st_ip;
                r.arp_oper = ARP_OP_REQ;
            end
            default: begin
                r.eth_type = ETH_ARP;
                r.l3_dest_addr = st_ip;
                r.arp_oper = ARP_OP_REPLY;
            end
        endcase
        return r;
    endfunction

    task automatic send_random(input int n);
        t_req        r;
        t_frame_kind kind;
        for (int i = 0; i < n; i++) begin
            kind = t_frame_kind'($urandom_range(0, 4));
            r = make_frame(kind);
            // break one header field now and then
            if ($urandom_range(0, 6) == 0) begin
                case ($urandom_range(0, 5))
                    0: r.dest_mac = rand48();
                    1: r.eth_type = 16'($urandom);
                    2: r.l3_dest_addr = $urandom;
                    3: r.ip_protocol = 8'($urandom);
                    4: r.icmp_msg_type = 8'($urandom);
                    default: r.arp_oper = 16'($urandom_range(0, 4));
                endcase
            end
            frame_q.push_back(r);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STN_MAC:  st_mac = data;
            CFG_STN_IP:   st_ip = data[31:0];
            CFG_BCAST_IP: st_bip = data[31:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (frame_q.size() != 0 || n_req_acc != n_req_sent || reply_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // request driver
    always @(negedge clk) begin : drv
        int gap_left;
        int burst_left;
        if (n_req_acc == n_req_sent) begin
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (rst_n && frame_q.size() != 0) begin
                in_req <= frame_q.pop_front();
                in_valid <= 1'b1;
                n_req_sent++;
                if (burst_left > 0) burst_left--;
                if (src_idle_on && burst_left == 0) begin
                    gap_left = $urandom_range(1, 8);
                    burst_left = $urandom_range(1, 10);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // response stall pattern
    always @(negedge clk) begin : snk
        if (snk_tick == 0) snk_pat = 16'($urandom);
        case (snk_mode)
            SNK_LIGHT: out_stall <= snk_pat[snk_tick] & snk_pat[snk_tick + 4'd3];
            SNK_HEAVY: out_stall <= snk_pat[snk_tick] | snk_pat[snk_tick + 4'd7];
            default:   out_stall <= 1'b0;
        endcase
        snk_tick++;
    end

    // accept requests, check responses
    always @(posedge clk) begin : mon
        t_rsp got;
        t_rsp want;
        cycles++;
        if (rst_n && in_valid && !in_stall) begin
            n_req_acc++;
            predict_reply(in_req);
        end
        if (rst_n && out_valid && !out_stall) begin
            got = out_rsp;
            n_words++;
            if (reply_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected response: act=%0d word=%h last=%b ip=%h mac=%h",
                             got.action, got.frame_word, got.word_last,
                             got.learn_ip, got.learn_mac);
            end else begin
                want = reply_q.pop_front();
                if (got.action !== want.action || got.frame_word !== want.frame_word
                    || got.word_last !== want.word_last || got.learn_ip !== want.learn_ip
                    || got.learn_mac !== want.learn_mac) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch %0d: expected act=%0d word=%h last=%b ip=%h mac=%h",
                                 errors, want.action, want.frame_word, want.word_last,
                                 want.learn_ip, want.learn_mac);
                        $display("             actual   act=%0d word=%h last=%b ip=%h mac=%h",
                                 got.action, got.frame_word, got.word_last,
                                 got.learn_ip, got.learn_mac);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", cycles);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stim
        t_req r;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // reset settings: local MAC and IP zero, broadcast all ones
        r = make_frame(FR_ECHO);
        r.dest_mac = '0;
        r.l3_dest_addr = '0;
        frame_q.push_back(r);
        r = make_frame(FR_UDP);
        r.dest_mac = MAC_BCAST;
        r.l3_dest_addr = 32'hFFFF_FFFF;
        frame_q.push_back(r);
        r = make_frame(FR_ARP_REQ);
        r.dest_mac = '0;
        frame_q.push_back(r);
        drain();

        write_reg(CFG_STN_MAC, 48'h0200_5E10_2030);
        write_reg(CFG_STN_IP, 48'hC0A8_0A01);
        write_reg(CFG_BCAST_IP, 48'hC0A8_0AFF);
        write_reg(CFG_UNUSED, rand48());

        r = make_frame(FR_ECHO);
        r.dest_mac = st_mac;
        r.l3_dest_addr = st_ip;
        r.icmp_echo_id = '0;
        r.icmp_sequence = 16'hFFFF;
        r.source_mac = MAC_BCAST;
        r.l3_source_addr = '0;
        frame_q.push_back(r);
        r.dest_mac = MAC_BCAST;
        r.l3_dest_addr = st_bip;
        r.icmp_echo_id = 16'hFFFF;
        r.icmp_sequence = '0;
        r.source_mac = '0;
        r.l3_source_addr = 32'hFFFF_FFFF;
        frame_q.push_back(r);
        r = make_frame(FR_UDP);
        r.l3_dest_addr = st_ip;
        frame_q.push_back(r);
        r.dest_mac = MAC_BCAST;
        r.l3_dest_addr = st_bip;
        frame_q.push_back(r);
        r = make_frame(FR_ECHO);
        r.ip_protocol = 8'd6;
        frame_q.push_back(r);
        r = make_frame(FR_ECHO);
        r.icmp_msg_type = '0;
        frame_q.push_back(r);
        r = make_frame(FR_ECHO);
        r.l3_dest_addr = 32'hC0A8_0B01;
        frame_q.push_back(r);
        r = make_frame(FR_ECHO);
        r.dest_mac = st_mac ^ 48'h1;
        frame_q.push_back(r);
        r = make_frame(FR_ARP_REQ);
        r.arp_sender_mac = MAC_BCAST;
        r.l3_source_addr = 32'hFFFF_FFFF;
        frame_q.push_back(r);
        r.arp_sender_mac = '0;
        r.l3_source_addr = '0;
        frame_q.push_back(r);
        r = make_frame(FR_ARP_REP);
        frame_q.push_back(r);
        r.arp_oper = '0;
        frame_q.push_back(r);
        r.arp_oper = 16'hFFFF;
        frame_q.push_back(r);
        r = make_frame(FR_ARP_REQ);
        r.l3_dest_addr = st_bip;
        frame_q.push_back(r);
        r = make_frame(FR_UDP);
        r.eth_type = '0;
        frame_q.push_back(r);
        r.eth_type = 16'hFFFF;
        frame_q.push_back(r);
        r.eth_type = 16'h86DD;
        frame_q.push_back(r);
        frame_q.push_back('1);
        frame_q.push_back('0);
        drain();

        src_idle_on = 1'b1;
        snk_mode = SNK_LIGHT;
        send_random(35);
        drain();

        write_reg(CFG_STN_MAC, MAC_BCAST);
        write_reg(CFG_STN_IP, 48'hFFFF_FFFF);
        write_reg(CFG_BCAST_IP, '0);
        snk_mode = SNK_HEAVY;
        send_random(30);
        drain();

        write_reg(CFG_STN_MAC, rand48());
        write_reg(CFG_STN_IP, {16'd0, $urandom});
        write_reg(CFG_BCAST_IP, {16'd0, $urandom});
        src_idle_on = 1'b0;
        snk_mode = SNK_LIGHT;
        send_random(25);
        // hold off until every pending response is out
        drain();
        src_idle_on = 1'b1;
        snk_mode = SNK_FREE;
        send_random(20);

        while (frame_q.size() != 0 || n_req_acc != n_req_sent || reply_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        errors += reply_q.size();

        $display("%0d requests: %0d echo, %0d arp reply, %0d learn, %0d udp, %0d drop",
                 n_req_acc, act_seen[ACT_ECHO], act_seen[ACT_ARP_REPLY],
                 act_seen[ACT_ARP_LEARN], act_seen[ACT_UDP], act_seen[ACT_DROP]);
        $display("%0d response words checked over four station settings, %0d errors",
                 n_words, errors);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
